// ===== hw/rtl/sv39w_pkg.sv =====
// ----------------------------------------------------------------------------
// sv39w_pkg
// Shared types and constants of the Sv39 page table walker.
// ----------------------------------------------------------------------------
package sv39w_pkg;

    localparam int VA_BITS    = 39;
    localparam int PAGE_SHIFT = 12;
    localparam int IDX_BITS   = 9;
    localparam int PTE_SHIFT  = 3;   // 8-byte entries
    localparam int ADDR_BITS  = 64;
    localparam int PPN_LSB    = 10;
    localparam int PPN_BITS   = 44;

    localparam int VPN0_LSB = PAGE_SHIFT;
    localparam int VPN1_LSB = PAGE_SHIFT + IDX_BITS;
    localparam int VPN2_LSB = PAGE_SHIFT + 2 * IDX_BITS;

    // PTE flag bit positions
    localparam int PTE_V = 0;
    localparam int PTE_R = 1;
    localparam int PTE_W = 2;
    localparam int PTE_X = 3;

    typedef logic [1:0] level_t;
    localparam level_t LEVEL_ROOT = 2'd2;
    localparam level_t LEVEL_MID  = 2'd1;
    localparam level_t LEVEL_LEAF = 2'd0;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_NOMAP = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    typedef enum logic {
        FUNC_XLATE = 1'b0,
        FUNC_ENTRY = 1'b1
    } func_t;

    typedef enum logic {
        CFG_ROOT_TABLE_ADDR = 1'b0,
        CFG_WINDOW_OFFSET   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic               busy;
        level_t             level;
        logic [VA_BITS-1:0] vaddr;
    } walk_state_t;

endpackage

// ===== hw/rtl/sv39_page_table_walker_core.sv =====
// ----------------------------------------------------------------------------
// sv39_page_table_walker_core
// Sv39 three-level page table walker, one memory entry per step.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries either a translate request
//   (func=0, vaddr) or a page table entry returned from memory (func=1,
//   entry_data). Every input transfer yields exactly one output transfer
//   (out_valid/out_stall): kind READ asks the host to fetch the entry at
//   address and send it back; DONE carries the translated window address;
//   NOMAP ends the walk; BAD flags an entry received while no walk is open.
//   out_valid rises once the item has passed the input register and then the
//   result register; out_stall can hold it in the input register between the
//   two. Throughput is one item per cycle while out_stall is low; the walk
//   itself is paced by the round trip through memory.
//   A new request while a walk is open drops the old walk.
//   cfg_we/cfg_index/cfg_data write root_table_addr (0) and window_offset
//   (1); write them only while the block is idle.
//   Reset clears the walk state, both config registers and both valid
//   flags. When out_stall holds, the result register keeps its data, the
//   input register may still fill once, and then in_stall rises.
// ----------------------------------------------------------------------------
module sv39_page_table_walker_core
    import sv39w_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [VA_BITS-1:0]   vaddr,
    input  logic [63:0]          entry_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           kind,
    output logic [ADDR_BITS-1:0] address,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [ADDR_BITS-1:0] cfg_data
);

    // config registers
    logic [ADDR_BITS-1:0] root_reg;
    logic [ADDR_BITS-1:0] window_reg;

    // input register
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_func_reg;
    logic [VA_BITS-1:0]   s1_vaddr_reg;
    logic [63:0]          s1_entry_reg;

    // result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    kind_t                out_kind_reg;
    logic [ADDR_BITS-1:0] out_addr_reg;

    // walk state
    walk_state_t          walk_reg;
    walk_state_t          walk_next;
    kind_t                kind_next;
    logic [ADDR_BITS-1:0] addr_next;

    logic                 out_free;
    logic                 s1_move;
    logic                 in_xfer;

    // result slot frees when empty or drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    assign s1_valid_next  = in_xfer ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_move ? 1'b1 : (out_valid_reg && out_stall);

    sv39w_step u_step (
        .state           (walk_reg),
        .func            (s1_func_reg),
        .vaddr           (s1_vaddr_reg),
        .entry_data      (s1_entry_reg),
        .root_table_addr (root_reg),
        .window_offset   (window_reg),
        .state_next      (walk_next),
        .kind            (kind_next),
        .address         (addr_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg      <= '0;
            window_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            walk_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_ROOT_TABLE_ADDR: root_reg   <= cfg_data;
                    CFG_WINDOW_OFFSET:   window_reg <= cfg_data;
                    default:             root_reg   <= root_reg;
                endcase
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            // state advances as the item leaves the input register
            if (s1_move)
            begin
                walk_reg <= walk_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_func_reg  <= func;
            s1_vaddr_reg <= vaddr;
            s1_entry_reg <= entry_data;
        end
        if (s1_move)
        begin
            out_kind_reg <= kind_next;
            out_addr_reg <= addr_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign address   = out_addr_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        walk_reg.level != 2'd3)
        else $error("walk level out of range");

    a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
        !walk_reg.busy |-> walk_reg.level == LEVEL_LEAF)
        else $error("idle walker with nonzero level");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && (kind_next == KIND_DONE || kind_next == KIND_NOMAP)
        |=> !walk_reg.busy)
        else $error("walk still busy after final result");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with free pipeline");

endmodule

// ===== hw/rtl/sv39w_step.sv =====
// ----------------------------------------------------------------------------
// sv39w_step
// One walk step: decodes a request or returned entry against the walk state
// and produces the next state and the result item.
// ----------------------------------------------------------------------------
module sv39w_step
    import sv39w_pkg::*;
(
    input  walk_state_t          state,
    input  logic                 func,
    input  logic [VA_BITS-1:0]   vaddr,
    input  logic [63:0]          entry_data,
    input  logic [ADDR_BITS-1:0] root_table_addr,
    input  logic [ADDR_BITS-1:0] window_offset,
    output walk_state_t          state_next,
    output kind_t                kind,
    output logic [ADDR_BITS-1:0] address
);

    logic [PPN_BITS-1:0]  ppn;
    logic [ADDR_BITS-1:0] page_base;
    level_t               level_dn;
    logic [IDX_BITS-1:0]  vpn_dn;
    logic [IDX_BITS-1:0]  vpn_root;
    logic [VA_BITS-1:0]   low_bits;
    logic                 is_pointer;

    assign ppn       = entry_data[PPN_LSB +: PPN_BITS];
    assign page_base = window_offset
                     + {{(ADDR_BITS-PPN_BITS-PAGE_SHIFT){1'b0}}, ppn, {PAGE_SHIFT{1'b0}}};
    assign level_dn  = state.level - 2'd1;
    assign vpn_root  = vaddr[VPN2_LSB +: IDX_BITS];
    assign is_pointer = (state.level != LEVEL_LEAF)
                      && !entry_data[PTE_R] && !entry_data[PTE_W] && !entry_data[PTE_X];

    // index into the next table
    always_comb
    begin
        case (level_dn)
            LEVEL_MID:  vpn_dn = state.vaddr[VPN1_LSB +: IDX_BITS];
            LEVEL_LEAF: vpn_dn = state.vaddr[VPN0_LSB +: IDX_BITS];
            default:    vpn_dn = state.vaddr[VPN2_LSB +: IDX_BITS];
        endcase
    end

    // page offset kept from the VA; superpages keep more bits
    always_comb
    begin
        case (state.level)
            LEVEL_LEAF: low_bits = {{(VA_BITS-VPN0_LSB){1'b0}},
                                    state.vaddr[VPN0_LSB-1:0]};
            LEVEL_MID:  low_bits = {{(VA_BITS-VPN1_LSB){1'b0}},
                                    state.vaddr[VPN1_LSB-1:0]};
            default:    low_bits = {{(VA_BITS-VPN2_LSB){1'b0}},
                                    state.vaddr[VPN2_LSB-1:0]};
        endcase
    end

    always_comb
    begin
        state_next = state;
        kind       = KIND_BAD;
        address    = '0;
        if (func == FUNC_XLATE)
        begin
            if (vaddr == '0)
            begin
                state_next.busy  = 1'b0;
                state_next.level = LEVEL_LEAF;
                kind             = KIND_NOMAP;
            end
            else
            begin
                state_next.busy  = 1'b1;
                state_next.level = LEVEL_ROOT;
                state_next.vaddr = vaddr;
                kind             = KIND_READ;
                address          = root_table_addr
                                 + {{(ADDR_BITS-IDX_BITS-PTE_SHIFT){1'b0}},
                                    vpn_root, {PTE_SHIFT{1'b0}}};
            end
        end
        else if (!state.busy)
        begin
            kind = KIND_BAD;
        end
        else if (!entry_data[PTE_V])
        begin
            state_next.busy  = 1'b0;
            state_next.level = LEVEL_LEAF;
            kind             = KIND_NOMAP;
        end
        else if (is_pointer)
        begin
            state_next.level = level_dn;
            kind             = KIND_READ;
            address          = page_base
                             + {{(ADDR_BITS-IDX_BITS-PTE_SHIFT){1'b0}},
                                vpn_dn, {PTE_SHIFT{1'b0}}};
        end
        else
        begin
            state_next.busy  = 1'b0;
            state_next.level = LEVEL_LEAF;
            kind             = KIND_DONE;
            address          = page_base + {{(ADDR_BITS-VA_BITS){1'b0}}, low_bits};
        end
    end

endmodule
